### design/longest_run_with_replacements_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the longest run with replacements unit
// Checks are clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LONGEST_RUN_WITH_REPLACEMENTS_UNIT_DEFINES_SVH
`define LONGEST_RUN_WITH_REPLACEMENTS_UNIT_DEFINES_SVH

// Condition holds at every clock edge outside reset.
`define LRR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define LRR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/lrr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrr_pkg
// Field widths and constants shared by the longest run unit and its channels.
// ----------------------------------------------------------------------------
package lrr_pkg;

    localparam int LETTER_W       = 5;
    localparam int LEN_W          = 11;
    localparam int REPL_W         = 11;
    localparam int ALPHABET       = 26;
    localparam int MAX_WINDOW_DEF = 1024;

    localparam logic [LETTER_W-1:0] ALPHABET_LIMIT = LETTER_W'(ALPHABET);

endpackage
`default_nettype wire

### design/lrr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrr channel interfaces
// Valid/ready channels for incoming letters and outgoing results.
// ----------------------------------------------------------------------------
interface lrr_in_if import lrr_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [LETTER_W-1:0] letter;
    logic                first;

    modport source (output valid, output letter, output first, input ready);
    modport sink   (input valid, input letter, input first, output ready);
endinterface

interface lrr_out_if import lrr_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] best_length;
    logic             too_long;

    modport source (output valid, output best_length, output too_long, input ready);
    modport sink   (input valid, input best_length, input too_long, output ready);
endinterface
`default_nettype wire

### design/longest_run_with_replacements_unit.sv
`default_nettype none
// The unit takes one letter per cycle and returns one result per letter in the
// cycle after the transfer: the longest stretch of the current string that
// max_replacements substitutions can make uniform, and a flag when the window
// hit the ring depth MAX_WINDOW. A letter with first set starts a new string.
// Codes at or above the alphabet size only clear state with first. The letter
// ring sits in a RAM whose registered read fetches the oldest letter for the
// next item in the same cycle the current item updates the counters, so the
// rate of one letter per cycle holds as long as results are taken. No
// clearing pass follows reset; the counters clear at once.
// ----------------------------------------------------------------------------
// longest_run_with_replacements_unit
// Sliding-window longest repeating letter run with a replacement budget.
// ----------------------------------------------------------------------------
`include "longest_run_with_replacements_unit_defines.svh"

module longest_run_with_replacements_unit import lrr_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [REPL_W-1:0] cfg_wr_data,
    lrr_in_if.sink                 letters,
    lrr_out_if.source              results
);

    localparam int CW = $clog2(MAX_WINDOW + 2);
    localparam int AW = $clog2(MAX_WINDOW);
    localparam int SW = ((CW > REPL_W) ? CW : REPL_W) + 1;
    localparam logic [CW-1:0] WIN_FULL = CW'(MAX_WINDOW);
    localparam logic [AW-1:0] POS_LAST = AW'(MAX_WINDOW - 1);

    logic [REPL_W-1:0]   max_repl_reg;
    logic [CW-1:0]       cnt_reg  [ALPHABET];
    logic [CW-1:0]       cnt_eff  [ALPHABET];
    logic [CW-1:0]       cnt_next [ALPHABET];
    logic [AW-1:0]       wp_reg, wp_eff, wp_next;
    logic [AW-1:0]       tail_reg, tail_eff, tail_next;
    logic [CW-1:0]       wl_reg, wl_eff, wl_next;
    logic [CW-1:0]       hc_reg, hc_eff, hc_next;
    logic [CW-1:0]       best_reg, best_eff, best_next;
    logic [LETTER_W-1:0] ring_mem [MAX_WINDOW];
    logic [LETTER_W-1:0] oldest_reg;
    logic [AW-1:0]       rd_addr;
    logic                ring_we;
    logic                in_accept;
    logic                letter_ok;
    logic                oldest_ok;
    logic                full;
    logic                evict;
    logic [CW-1:0]       sel_cnt;
    logic [CW-1:0]       sel_after;
    logic [CW-1:0]       new_len;
    logic [SW-1:0]       budget;
    logic                out_valid_reg;
    logic [LEN_W-1:0]    out_best_reg;
    logic                out_too_long_reg;

    assign letters.ready       = !out_valid_reg || results.ready;
    assign in_accept           = letters.valid && letters.ready;
    assign results.valid       = out_valid_reg;
    assign results.best_length = out_best_reg;
    assign results.too_long    = out_too_long_reg;

    // Scalar state as seen by this letter, after any new-string clear.
    always_comb
    begin
        wp_eff    = letters.first ? '0 : wp_reg;
        tail_eff  = letters.first ? '0 : tail_reg;
        wl_eff    = letters.first ? '0 : wl_reg;
        hc_eff    = letters.first ? '0 : hc_reg;
        best_eff  = letters.first ? '0 : best_reg;
        letter_ok = letters.letter < ALPHABET_LIMIT;
        oldest_ok = oldest_reg < ALPHABET_LIMIT;
    end

    always_comb
    begin
        sel_cnt = '0;
        for (int i = 0; i < ALPHABET; i++)
        begin
            cnt_eff[i] = letters.first ? '0 : cnt_reg[i];
            if (letters.letter == LETTER_W'(i))
            begin
                sel_cnt = cnt_eff[i];
            end
        end
    end

    always_comb
    begin
        sel_after = sel_cnt + CW'(1);
        hc_next   = (letter_ok && sel_after > hc_eff) ? sel_after : hc_eff;
        new_len   = wl_eff + CW'(1);
        full      = wl_eff == WIN_FULL;
        budget    = SW'(max_repl_reg) + SW'(hc_next);
        evict     = letter_ok && (full || SW'(new_len) > budget);

        if (!letter_ok || evict)
        begin
            wl_next = wl_eff;
        end
        else
        begin
            wl_next = new_len;
        end

        if (letter_ok)
        begin
            wp_next = (wp_eff == POS_LAST) ? '0 : wp_eff + AW'(1);
        end
        else
        begin
            wp_next = wp_eff;
        end

        // Oldest letter leaves: advance the tail.
        if (evict)
        begin
            tail_next = (tail_eff == POS_LAST) ? '0 : tail_eff + AW'(1);
        end
        else
        begin
            tail_next = tail_eff;
        end

        best_next = (wl_next > best_eff) ? wl_next : best_eff;
        rd_addr   = in_accept ? tail_next : tail_reg;
        ring_we   = in_accept && letter_ok;
    end

    // Each counter counts up for the new letter and down for the leaving one.
    always_comb
    begin
        logic [CW-1:0] after;
        logic          dec;
        for (int i = 0; i < ALPHABET; i++)
        begin
            after = cnt_eff[i] + CW'(letter_ok && letters.letter == LETTER_W'(i));
            dec   = evict && oldest_ok && oldest_reg == LETTER_W'(i) && after != '0;
            cnt_next[i] = after - CW'(dec);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_repl_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            max_repl_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ALPHABET; i++)
            begin
                cnt_reg[i] <= '0;
            end
            wp_reg   <= '0;
            tail_reg <= '0;
            wl_reg   <= '0;
            hc_reg   <= '0;
            best_reg <= '0;
        end
        else if (in_accept)
        begin
            for (int i = 0; i < ALPHABET; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
            wp_reg   <= wp_next;
            tail_reg <= tail_next;
            wl_reg   <= wl_next;
            hc_reg   <= hc_next;
            best_reg <= best_next;
        end
    end

    // Letter ring; read the next oldest entry, bypassing a same-cycle write.
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[wp_eff] <= letters.letter;
        end
        if (ring_we && rd_addr == wp_eff)
        begin
            oldest_reg <= letters.letter;
        end
        else
        begin
            oldest_reg <= ring_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_best_reg     <= LEN_W'(best_next);
            out_too_long_reg <= letter_ok && full;
        end
    end

    `LRR_ASSERT_ALWAYS(a_window_bounded, wl_reg <= WIN_FULL, "window longer than ring")
    `LRR_ASSERT_ALWAYS(a_best_covers_window, best_reg >= wl_reg, "best below window length")
    `LRR_ASSERT_NEXT(a_window_no_shrink, in_accept && !letters.first, wl_reg >= $past(wl_reg), "window shrank within a string")

endmodule
`default_nettype wire
